>>> design/rle_image_window_writer_assert.svh
// assertion helpers shared by the design files
`ifndef RLE_IMAGE_WINDOW_WRITER_ASSERT_SVH
`define RLE_IMAGE_WINDOW_WRITER_ASSERT_SVH

// checked only outside reset
`define RLEW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define RLEW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/rlew_pkg.sv
package rlew_pkg;

  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_RUN    = 2'd1,
    OP_PULL   = 2'd2,
    OP_FINISH = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_OVERFLOW = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_NO_PIXEL = 3'd3,
    ST_PENDING  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    BURST_WINDOW = 2'd0,
    BURST_PIXEL  = 2'd1,
    BURST_STATUS = 2'd2
  } burst_t;

  localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
  localparam logic [7:0] CMD_ROW_SET      = 8'h2B;
  localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

  // byte positions inside a burst
  localparam logic [3:0] WIN_LAST_IDX = 4'd10;
  localparam logic [3:0] PIX_LAST_IDX = 4'd1;

  // one burst of link bytes or a status report
  typedef struct packed {
    burst_t      kind;
    status_t     status;
    logic [15:0] word0;  // x start, or pixel colour
    logic [15:0] word1;  // x end
    logic [15:0] word2;  // y start
    logic [15:0] word3;  // y end
  } desc_t;

endpackage

>>> design/rlew_in_if.sv
interface rlew_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] x_start;
  logic [15:0] y_start;
  logic [15:0] img_width;
  logic [15:0] img_height;
  logic [15:0] run_color;
  logic [15:0] run_length;

  modport source (output valid, operation, x_start, y_start, img_width, img_height,
                  run_color, run_length, input ready);
  modport sink (input valid, operation, x_start, y_start, img_width, img_height,
                run_color, run_length, output ready);
endinterface

>>> design/rlew_out_if.sv
interface rlew_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] out_byte;
  logic       data_flag;
  logic [2:0] status;
  logic       last;

  modport source (output valid, kind, out_byte, data_flag, status, last, input ready);
  modport sink (input valid, kind, out_byte, data_flag, status, last, output ready);
endinterface

>>> design/rlew_state.sv
`include "rle_image_window_writer_assert.svh"

module rlew_state (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_wdata,
  rlew_in_if.sink        in_chan,
  input  logic           desc_ready,
  output rlew_pkg::desc_t desc,
  output logic           desc_valid
);

  logic [15:0] row_offset_r;
  logic [31:0] pixel_total_r, pixel_total_nxt;
  logic [31:0] pixels_sent_r, pixels_sent_nxt;
  logic [15:0] current_color_r, current_color_nxt;
  logic [15:0] run_left_r, run_left_nxt;
  logic        error_seen_r, error_seen_nxt;

  logic            accept;
  logic            has_result;
  rlew_pkg::op_t   op;
  logic [32:0]     run_end;
  logic [32:0]     committed;

  assign in_chan.ready = desc_ready;
  assign accept        = in_chan.valid && desc_ready;
  assign op            = rlew_pkg::op_t'(in_chan.operation);
  assign run_end       = {1'b0, pixels_sent_r} + {17'd0, in_chan.run_length};
  assign committed     = {1'b0, pixels_sent_r} + {17'd0, run_left_r};
  assign desc_valid    = accept && has_result;

  always_comb begin
    pixel_total_nxt   = pixel_total_r;
    pixels_sent_nxt   = pixels_sent_r;
    current_color_nxt = current_color_r;
    run_left_nxt      = run_left_r;
    error_seen_nxt    = error_seen_r;
    has_result        = 1'b1;
    desc.kind         = rlew_pkg::BURST_STATUS;
    desc.status       = rlew_pkg::ST_OK;
    desc.word0        = current_color_r;
    desc.word1        = in_chan.x_start + in_chan.img_width - 16'd1;
    desc.word2        = in_chan.y_start + row_offset_r;
    desc.word3        = in_chan.y_start + in_chan.img_height - 16'd1 + row_offset_r;
    unique case (op)
      rlew_pkg::OP_BEGIN: begin
        desc.kind         = rlew_pkg::BURST_WINDOW;
        desc.word0        = in_chan.x_start;
        pixel_total_nxt   = in_chan.img_width * in_chan.img_height;
        pixels_sent_nxt   = '0;
        current_color_nxt = '0;
        run_left_nxt      = '0;
        error_seen_nxt    = 1'b0;
      end
      rlew_pkg::OP_RUN: begin
        priority if (error_seen_r || (pixels_sent_r >= pixel_total_r)) begin
          has_result = 1'b0;
        end else if (run_left_r != 16'd0) begin
          desc.status = rlew_pkg::ST_PENDING;
        end else if (run_end > {1'b0, pixel_total_r}) begin
          desc.status    = rlew_pkg::ST_OVERFLOW;
          error_seen_nxt = 1'b1;
        end else begin
          current_color_nxt = in_chan.run_color;
          run_left_nxt      = in_chan.run_length;
        end
      end
      rlew_pkg::OP_PULL: begin
        if (run_left_r == 16'd0) begin
          desc.status = rlew_pkg::ST_NO_PIXEL;
        end else begin
          desc.kind       = rlew_pkg::BURST_PIXEL;
          run_left_nxt    = run_left_r - 16'd1;
          pixels_sent_nxt = pixels_sent_r + 32'd1;
        end
      end
      rlew_pkg::OP_FINISH: begin
        priority if (error_seen_r) begin
          desc.status = rlew_pkg::ST_OVERFLOW;
        end else if (run_left_r != 16'd0) begin
          desc.status = rlew_pkg::ST_PENDING;
        end else if (pixels_sent_r != pixel_total_r) begin
          desc.status = rlew_pkg::ST_MISMATCH;
        end else begin
          desc.status = rlew_pkg::ST_OK;
        end
      end
      default: has_result = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_offset_r    <= '0;
      pixel_total_r   <= '0;
      pixels_sent_r   <= '0;
      current_color_r <= '0;
      run_left_r      <= '0;
      error_seen_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        row_offset_r <= cfg_wdata;
      end
      if (accept) begin
        pixel_total_r   <= pixel_total_nxt;
        pixels_sent_r   <= pixels_sent_nxt;
        current_color_r <= current_color_nxt;
        run_left_r      <= run_left_nxt;
        error_seen_r    <= error_seen_nxt;
      end
    end
  end

  // loaded runs never promise more pixels than the window holds
  `RLEW_ASSERT(a_run_within_total, committed <= {1'b0, pixel_total_r}, "run exceeds window")
  `RLEW_ASSERT(a_pull_counts, (accept && op == rlew_pkg::OP_PULL && run_left_r != 16'd0) |=> (pixels_sent_r == $past(pixels_sent_r) + 32'd1), "pull not counted")
  // after an overflow a run gives no result
  `RLEW_ASSERT(a_run_silent_on_error, (accept && op == rlew_pkg::OP_RUN && error_seen_r) |-> !desc_valid, "run after error gave a result")

endmodule

>>> design/rlew_emit.sv
`include "rle_image_window_writer_assert.svh"

module rlew_emit (
  input  logic            clk,
  input  logic            rst_n,
  input  rlew_pkg::desc_t desc,
  input  logic            desc_valid,
  output logic            desc_ready,
  rlew_out_if.source      out_chan
);

  rlew_pkg::desc_t burst_r;
  logic            burst_valid_r, burst_valid_nxt;
  logic [3:0]      idx_r, idx_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic       kind_r;
  logic [7:0] byte_r;
  logic       flag_r;
  logic [2:0] status_r;
  logic       last_r;

  logic       cur_kind;
  logic [7:0] cur_byte;
  logic       cur_flag;
  logic       cur_last;
  logic       out_load;
  logic       burst_done;

  assign out_load   = burst_valid_r && (!out_valid_r || out_chan.ready);
  assign burst_done = out_load && cur_last;
  assign desc_ready = !burst_valid_r || burst_done;

  // byte picker for the current burst position
  always_comb begin
    cur_kind = 1'b0;
    cur_byte = 8'd0;
    cur_flag = 1'b1;
    cur_last = 1'b0;
    unique case (burst_r.kind)
      rlew_pkg::BURST_WINDOW: begin
        unique case (idx_r)
          4'd0: begin cur_byte = rlew_pkg::CMD_COLUMN_SET; cur_flag = 1'b0; end
          4'd1: cur_byte = burst_r.word0[15:8];
          4'd2: cur_byte = burst_r.word0[7:0];
          4'd3: cur_byte = burst_r.word1[15:8];
          4'd4: cur_byte = burst_r.word1[7:0];
          4'd5: begin cur_byte = rlew_pkg::CMD_ROW_SET; cur_flag = 1'b0; end
          4'd6: cur_byte = burst_r.word2[15:8];
          4'd7: cur_byte = burst_r.word2[7:0];
          4'd8: cur_byte = burst_r.word3[15:8];
          4'd9: cur_byte = burst_r.word3[7:0];
          default: begin
            cur_byte = rlew_pkg::CMD_MEMORY_WRITE;
            cur_flag = 1'b0;
            cur_last = 1'b1;
          end
        endcase
      end
      rlew_pkg::BURST_PIXEL: begin
        cur_byte = idx_r[0] ? burst_r.word0[7:0] : burst_r.word0[15:8];
        cur_last = idx_r[0];
      end
      default: begin
        cur_kind = 1'b1;
        cur_flag = 1'b0;
        cur_last = 1'b1;
      end
    endcase
  end

  always_comb begin
    burst_valid_nxt = burst_valid_r;
    idx_nxt         = idx_r;
    out_valid_nxt   = out_valid_r;
    if (burst_done) begin
      burst_valid_nxt = 1'b0;
    end
    if (out_load) begin
      idx_nxt = idx_r + 4'd1;
    end
    if (desc_valid && desc_ready) begin
      burst_valid_nxt = 1'b1;
      idx_nxt         = 4'd0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_valid_r <= 1'b0;
      idx_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      burst_valid_r <= burst_valid_nxt;
      idx_r         <= idx_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (desc_valid && desc_ready) begin
      burst_r <= desc;
    end
    if (out_load) begin
      kind_r   <= cur_kind;
      byte_r   <= cur_byte;
      flag_r   <= cur_flag;
      status_r <= cur_kind ? burst_r.status : rlew_pkg::ST_OK;
      last_r   <= cur_last;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.kind      = kind_r;
  assign out_chan.out_byte  = byte_r;
  assign out_chan.data_flag = flag_r;
  assign out_chan.status    = status_r;
  assign out_chan.last      = last_r;

  `RLEW_ASSERT(a_idx_in_range, burst_valid_r |-> (idx_r <= rlew_pkg::WIN_LAST_IDX), "burst index past end")
  `RLEW_ASSERT(a_pixel_idx, (burst_valid_r && burst_r.kind == rlew_pkg::BURST_PIXEL) |-> (idx_r <= rlew_pkg::PIX_LAST_IDX), "pixel index past end")
  `RLEW_ASSERT(a_stall_holds_idx, (burst_valid_r && out_valid_r && !out_chan.ready) |=> $stable(idx_r), "index moved under stall")

endmodule

>>> design/rle_image_window_writer.sv
// channel | direction | carries
// in_chan | sink      | operation, window geometry, run colour and length
// out_chan| source    | link byte with command/data flag, or a status report
// cfg     | write     | row_offset register (cfg_we, cfg_wdata)
//
// an item is accepted in the cycle its burst descriptor is built; a window
// burst then has 11 link bytes, a pixel 2 and a status report 1, sent by the
// output register at one byte per cycle while out_chan is ready
// the next item is taken in the cycle the last byte of the current burst
// moves into the output register; an ignored run is accepted but sends nothing
// reset is synchronous, active low, and clears all counters
// out_chan stalls hold the output register and the burst index in place

module rle_image_window_writer (
  input  logic        clk,
  input  logic        rst_n,
  rlew_in_if.sink     in_chan,
  rlew_out_if.source  out_chan,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  // descriptor handed from the state update to the byte sequencer
  rlew_pkg::desc_t desc;
  logic            desc_valid;
  logic            desc_ready;

  // counters, run tracking and the decode of each accepted transfer
  rlew_state u_state (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_chan    (in_chan),
    .desc_ready (desc_ready),
    .desc       (desc),
    .desc_valid (desc_valid)
  );

  // burst register, byte index and the output register
  rlew_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc       (desc),
    .desc_valid (desc_valid),
    .desc_ready (desc_ready),
    .out_chan   (out_chan)
  );

endmodule

>>> dv/tb_top.sv
module tb_top;

  // cycles with no transfer on either channel before the run is abandoned
  localparam int unsigned QUIET_LIMIT   = 2000;
  // cycles left after the last result so an ignored run can finish its cycle
  localparam int unsigned SETTLE_CYCLES = 4;
  // cycles waited at the end for any stray result
  localparam int unsigned TAIL_CYCLES   = 16;
  localparam int unsigned REPORT_LIMIT  = 10;

  // one result beat as it appears on the output channel
  typedef struct packed {
    logic              kind;
    logic [7:0]        link_byte;
    logic              data_flag;
    rlew_pkg::status_t status;
    logic              last;
  } link_beat_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [15:0] cfg_wdata;

  rlew_in_if  in_if ();
  rlew_out_if out_if ();

  rle_image_window_writer u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // predictor copy of the register and the frame state
  logic [15:0] row_offset_q;
  logic [31:0] pixel_goal;
  logic [31:0] pixels_done;
  logic [15:0] run_colour;
  logic [15:0] run_remaining;
  logic        overflow_flag;

  link_beat_t  pending_beats[$];

  bit          idle_on;
  int unsigned items_sent;
  int unsigned beats_seen;
  int unsigned frames_run;
  int unsigned cfg_writes;
  int unsigned failures;
  int unsigned quiet_cycles;

  // clock, period 8
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------
  // predictor: expected beats of one accepted item
  // ---------------------------------------------------------------------
  function automatic link_beat_t link_byte_beat(input logic [7:0] b, input logic is_data);
    link_beat_t beat;
    beat.kind      = 1'b0;
    beat.link_byte = b;
    beat.data_flag = is_data;
    beat.status    = rlew_pkg::ST_OK;
    beat.last      = 1'b0;
    return beat;
  endfunction

  function automatic link_beat_t status_beat(input rlew_pkg::status_t st);
    link_beat_t beat;
    beat.kind      = 1'b1;
    beat.link_byte = 8'h00;
    beat.data_flag = 1'b0;
    beat.status    = st;
    beat.last      = 1'b1;
    return beat;
  endfunction

  task automatic predict_item(input rlew_pkg::op_t op,
                              input logic [15:0] xs, ys, w, h, colour, len);
    logic [15:0] x_end;
    logic [15:0] y_top;
    logic [15:0] y_end;
    link_beat_t  tail;
    case (op)
      rlew_pkg::OP_BEGIN: begin
        // all window coordinates wrap at 16 bits
        x_end = xs + w - 16'd1;
        y_top = ys + row_offset_q;
        y_end = ys + h - 16'd1 + row_offset_q;
        pending_beats.push_back(link_byte_beat(rlew_pkg::CMD_COLUMN_SET, 1'b0));
        pending_beats.push_back(link_byte_beat(xs[15:8], 1'b1));
        pending_beats.push_back(link_byte_beat(xs[7:0], 1'b1));
        pending_beats.push_back(link_byte_beat(x_end[15:8], 1'b1));
        pending_beats.push_back(link_byte_beat(x_end[7:0], 1'b1));
        pending_beats.push_back(link_byte_beat(rlew_pkg::CMD_ROW_SET, 1'b0));
        pending_beats.push_back(link_byte_beat(y_top[15:8], 1'b1));
        pending_beats.push_back(link_byte_beat(y_top[7:0], 1'b1));
        pending_beats.push_back(link_byte_beat(y_end[15:8], 1'b1));
        pending_beats.push_back(link_byte_beat(y_end[7:0], 1'b1));
        tail = link_byte_beat(rlew_pkg::CMD_MEMORY_WRITE, 1'b0);
        tail.last = 1'b1;
        pending_beats.push_back(tail);
        pixel_goal    = 32'(w) * 32'(h);
        pixels_done   = '0;
        run_colour    = '0;
        run_remaining = '0;
        overflow_flag = 1'b0;
      end
      rlew_pkg::OP_RUN: begin
        // after an overflow or a complete frame the run gives nothing
        if (!overflow_flag && pixels_done < pixel_goal) begin
          if (run_remaining != 16'd0) begin
            pending_beats.push_back(status_beat(rlew_pkg::ST_PENDING));
          end else if ({1'b0, pixels_done} + 33'(len) > {1'b0, pixel_goal}) begin
            overflow_flag = 1'b1;
            pending_beats.push_back(status_beat(rlew_pkg::ST_OVERFLOW));
          end else begin
            run_colour    = colour;
            run_remaining = len;
            pending_beats.push_back(status_beat(rlew_pkg::ST_OK));
          end
        end
      end
      rlew_pkg::OP_PULL: begin
        if (run_remaining == 16'd0) begin
          pending_beats.push_back(status_beat(rlew_pkg::ST_NO_PIXEL));
        end else begin
          pending_beats.push_back(link_byte_beat(run_colour[15:8], 1'b1));
          tail = link_byte_beat(run_colour[7:0], 1'b1);
          tail.last = 1'b1;
          pending_beats.push_back(tail);
          run_remaining = run_remaining - 16'd1;
          pixels_done   = pixels_done + 32'd1;
        end
      end
      default: begin
        // finish: error first, then a pending run, then the pixel count
        if (overflow_flag) begin
          pending_beats.push_back(status_beat(rlew_pkg::ST_OVERFLOW));
        end else if (run_remaining != 16'd0) begin
          pending_beats.push_back(status_beat(rlew_pkg::ST_PENDING));
        end else if (pixels_done != pixel_goal) begin
          pending_beats.push_back(status_beat(rlew_pkg::ST_MISMATCH));
        end else begin
          pending_beats.push_back(status_beat(rlew_pkg::ST_OK));
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------
  // input side: one item per call, started and finished at a falling edge
  // ---------------------------------------------------------------------
  task automatic send_item(input rlew_pkg::op_t op,
                           input logic [15:0] xs, ys, w, h, colour, len);
    // fields the operation does not use carry noise
    if (op != rlew_pkg::OP_BEGIN) begin
      xs = 16'($urandom);
      ys = 16'($urandom);
      w  = 16'($urandom);
      h  = 16'($urandom);
    end
    if (op != rlew_pkg::OP_RUN) begin
      colour = 16'($urandom);
      len    = 16'($urandom);
    end
    while (idle_on && $urandom_range(0, 99) < 21) @(negedge clk);
    in_if.operation  = op;
    in_if.x_start    = xs;
    in_if.y_start    = ys;
    in_if.img_width  = w;
    in_if.img_height = h;
    in_if.run_color  = colour;
    in_if.run_length = len;
    in_if.valid      = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    predict_item(op, xs, ys, w, h, colour, len);
    items_sent++;
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  // hold the sender until every expected result has come out
  task automatic wait_for_drain();
    while (pending_beats.size() != 0) @(negedge clk);
  endtask

  // register writes only while the block is idle
  task automatic write_row_offset(input logic [15:0] value);
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we       = 1'b0;
    row_offset_q = value;
    cfg_writes++;
  endtask

  // ---------------------------------------------------------------------
  // output side: random back-pressure and the result check
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    out_if.ready <= !(idle_on && $urandom_range(0, 99) < 21);
  end

  always @(posedge clk) begin
    link_beat_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      beats_seen++;
      if (pending_beats.size() == 0) begin
        if (failures < REPORT_LIMIT) begin
          $display("unexpected result: kind %0b byte %02h flag %0b status %0d last %0b",
                   out_if.kind, out_if.out_byte, out_if.data_flag, out_if.status,
                   out_if.last);
        end
        failures++;
      end else begin
        want = pending_beats.pop_front();
        if (out_if.kind !== want.kind || out_if.out_byte !== want.link_byte ||
            out_if.data_flag !== want.data_flag || out_if.status !== want.status ||
            out_if.last !== want.last) begin
          if (failures < REPORT_LIMIT) begin
            $display("result %0d mismatch: expected kind %0b byte %02h flag %0b status %0d last %0b",
                     beats_seen, want.kind, want.link_byte, want.data_flag, want.status,
                     want.last);
            $display("    actual   kind %0b byte %02h flag %0b status %0d last %0b",
                     out_if.kind, out_if.out_byte, out_if.data_flag, out_if.status,
                     out_if.last);
          end
          failures++;
        end
      end
    end
  end

  // watchdog: a stuck handshake ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // extremes of the fields and every early-out of the state machine
  task automatic test_directed();
    // nothing opened yet: finish sees an empty frame, run is ignored
    send_item(rlew_pkg::OP_FINISH, 0, 0, 0, 0, 0, 0);
    send_item(rlew_pkg::OP_RUN, 0, 0, 0, 0, 16'h1234, 16'd1);
    send_item(rlew_pkg::OP_PULL, 0, 0, 0, 0, 0, 0);
    // zero-sized window at the far corner, coordinates wrap
    send_item(rlew_pkg::OP_BEGIN, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 0, 0);
    send_item(rlew_pkg::OP_RUN, 0, 0, 0, 0, 16'hFFFF, 16'd1);
    send_item(rlew_pkg::OP_FINISH, 0, 0, 0, 0, 0, 0);
    // largest window, longest run
    send_item(rlew_pkg::OP_BEGIN, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 0, 0);
    send_item(rlew_pkg::OP_RUN, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF);
    send_item(rlew_pkg::OP_PULL, 0, 0, 0, 0, 0, 0);
    send_item(rlew_pkg::OP_RUN, 0, 0, 0, 0, 16'h0000, 16'd1);
    send_item(rlew_pkg::OP_FINISH, 0, 0, 0, 0, 0, 0);
    // overflow, then a run is ignored and finish reports the overflow
    send_item(rlew_pkg::OP_BEGIN, 16'h1234, 16'h0000, 16'd2, 16'd2, 0, 0);
    send_item(rlew_pkg::OP_RUN, 0, 0, 0, 0, 16'h0000, 16'hFFFF);
    send_item(rlew_pkg::OP_RUN, 0, 0, 0, 0, 16'h5555, 16'd1);
    send_item(rlew_pkg::OP_PULL, 0, 0, 0, 0, 0, 0);
    send_item(rlew_pkg::OP_FINISH, 0, 0, 0, 0, 0, 0);
    // zero-length run, short frame, then a complete frame
    send_item(rlew_pkg::OP_BEGIN, 16'h0000, 16'h0000, 16'd1, 16'd3, 0, 0);
    send_item(rlew_pkg::OP_RUN, 0, 0, 0, 0, 16'hA5A5, 16'd0);
    send_item(rlew_pkg::OP_RUN, 0, 0, 0, 0, 16'hF800, 16'd2);
    send_item(rlew_pkg::OP_PULL, 0, 0, 0, 0, 0, 0);
    send_item(rlew_pkg::OP_PULL, 0, 0, 0, 0, 0, 0);
    send_item(rlew_pkg::OP_FINISH, 0, 0, 0, 0, 0, 0);
    send_item(rlew_pkg::OP_RUN, 0, 0, 0, 0, 16'h07E0, 16'd1);
    send_item(rlew_pkg::OP_PULL, 0, 0, 0, 0, 0, 0);
    // run after completion is ignored
    send_item(rlew_pkg::OP_RUN, 0, 0, 0, 0, 16'h001F, 16'd1);
    send_item(rlew_pkg::OP_FINISH, 0, 0, 0, 0, 0, 0);
  endtask

  // window rows under several offsets, the largest included
  task automatic test_row_offset();
    logic [15:0] offsets[3];
    offsets = '{16'hFFFF, 16'h8000, 16'h0000};
    offsets[2] = 16'($urandom);
    foreach (offsets[i]) begin
      write_row_offset(offsets[i]);
      send_item(rlew_pkg::OP_BEGIN, 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 0, 0);
      send_item(rlew_pkg::OP_FINISH, 0, 0, 0, 0, 0, 0);
    end
  endtask

  // mostly well-formed frames with random content, some broken sequences
  task automatic test_random_frames(input int unsigned count);
    int unsigned stop_at;
    int unsigned chunks;
    int unsigned cap;
    int unsigned pick;
    logic [31:0] remaining;
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] len;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      frames_run++;
      // small windows mostly, now and then the full field range
      if ($urandom_range(0, 9) == 0) begin
        w = 16'($urandom);
        h = 16'($urandom);
      end else begin
        w = 16'($urandom_range(1, 4));
        h = 16'($urandom_range(1, 4));
      end
      send_item(rlew_pkg::OP_BEGIN, 16'($urandom), 16'($urandom), w, h, 0, 0);
      chunks = 0;
      while (!overflow_flag && pixels_done < pixel_goal && chunks < 8) begin
        chunks++;
        remaining = pixel_goal - pixels_done;
        cap  = (remaining > 32'd6) ? 6 : remaining;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          // long run, usually more than the window holds
          send_item(rlew_pkg::OP_RUN, 0, 0, 0, 0, 16'($urandom), 16'($urandom));
          if (overflow_flag) begin
            send_item(rlew_pkg::OP_RUN, 0, 0, 0, 0, 16'($urandom), 16'd1);
          end
        end else if (pick < 7) begin
          send_item(rlew_pkg::OP_PULL, 0, 0, 0, 0, 0, 0);
        end else if (pick < 10) begin
          send_item(rlew_pkg::OP_FINISH, 0, 0, 0, 0, 0, 0);
        end else if (pick < 14) begin
          // second run and a finish while the first is still pending
          len = 16'($urandom_range(1, cap));
          send_item(rlew_pkg::OP_RUN, 0, 0, 0, 0, 16'($urandom), len);
          send_item(rlew_pkg::OP_RUN, 0, 0, 0, 0, 16'($urandom), 16'($urandom));
          send_item(rlew_pkg::OP_FINISH, 0, 0, 0, 0, 0, 0);
          repeat (len) send_item(rlew_pkg::OP_PULL, 0, 0, 0, 0, 0, 0);
        end else begin
          len = 16'($urandom_range(0, cap));
          send_item(rlew_pkg::OP_RUN, 0, 0, 0, 0, 16'($urandom), len);
          repeat (len) send_item(rlew_pkg::OP_PULL, 0, 0, 0, 0, 0, 0);
        end
        // sender holds off until the output side has caught up
        if ($urandom_range(0, 15) == 0) wait_for_drain();
      end
      if (!overflow_flag && pixels_done == pixel_goal && $urandom_range(0, 3) == 0) begin
        send_item(rlew_pkg::OP_RUN, 0, 0, 0, 0, 16'($urandom), 16'($urandom));
      end
      send_item(rlew_pkg::OP_FINISH, 0, 0, 0, 0, 0, 0);
    end
  endtask

  // ---------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------
  initial begin
    in_if.valid      = 1'b0;
    in_if.operation  = rlew_pkg::OP_BEGIN;
    in_if.x_start    = '0;
    in_if.y_start    = '0;
    in_if.img_width  = '0;
    in_if.img_height = '0;
    in_if.run_color  = '0;
    in_if.run_length = '0;
    out_if.ready     = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    rst_n            = 1'b0;
    idle_on          = 1'b1;
    row_offset_q     = '0;
    pixel_goal       = '0;
    pixels_done      = '0;
    run_colour       = '0;
    run_remaining    = '0;
    overflow_flag    = 1'b0;
    items_sent       = 0;
    beats_seen       = 0;
    frames_run       = 0;
    cfg_writes       = 0;
    failures         = 0;

    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_row_offset();

    write_row_offset(16'($urandom));
    test_random_frames(40);

    // a long stretch with both sides always ready
    idle_on = 1'b0;
    write_row_offset(16'h0000);
    test_random_frames(30);

    idle_on = 1'b1;
    write_row_offset(16'hFFFF);
    test_random_frames(40);

    wait_for_drain();
    repeat (TAIL_CYCLES) @(negedge clk);

    if (pending_beats.size() != 0) begin
      $display("%0d expected results never arrived", pending_beats.size());
      failures++;
    end

    $display("covered %0d items (%0d random frames) and %0d result beats",
             items_sent, frames_run, beats_seen);
    $display("row offset written %0d times, %0d failures", cfg_writes, failures);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/rlew_pkg.sv
design/rlew_in_if.sv
design/rlew_out_if.sv
design/rlew_state.sv
design/rlew_emit.sv
design/rle_image_window_writer.sv
dv/tb_top.sv
